@@ rtl/core/rbwd_pkg.sv @@
// shared types and constants for the repeated bit window detector
package rbwd_pkg;

	localparam int MIN_LEN = 4;
	localparam int POS_W   = 32;
	localparam int PAT_W   = 20;
	localparam int LEN_W   = 5;

	localparam logic [1:0] STAT_FILL      = 2'd0;
	localparam logic [1:0] STAT_NEW       = 2'd1;
	localparam logic [1:0] STAT_FIRST_DUP = 2'd2;
	localparam logic [1:0] STAT_LATCHED   = 2'd3;

	typedef struct packed {
		logic func;
		logic bit_in;
	} in_word_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [POS_W-1:0] position;
		logic [PAT_W-1:0] pattern;
	} out_word_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic accept;
		logic check;
		logic load_out;
		logic clr_en;
	} cmd_t;

	typedef struct packed {
		logic in_restart;
		logic in_fill;
		logic rst_pend;
		logic slot_free;
		logic clr_done;
	} sts_t;

endpackage

@@ rtl/core/rbwd_datapath.sv @@
// window, counters, seen bitmap memory and output register
module rbwd_datapath #(
	parameter int MAX_LEN = 20
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [rbwd_pkg::LEN_W-1:0]  cfg_wr_data,
	input  rbwd_pkg::in_word_t          in_data,
	input  logic                        out_stall,
	output logic                        out_valid,
	output rbwd_pkg::out_word_t         out_data,
	input  rbwd_pkg::cmd_t              cmd,
	output rbwd_pkg::sts_t              sts
);
	import rbwd_pkg::*;

	localparam int AW = MAX_LEN - 3;
	localparam int LW = ($clog2(MAX_LEN + 1) > LEN_W) ? $clog2(MAX_LEN + 1) : LEN_W;
	localparam logic [MAX_LEN-1:0] ONE_W = MAX_LEN'(1);
	localparam logic [POS_W-1:0] CNT_MAX = {POS_W{1'b1}};

	logic [7:0]         mem [2**AW];
	logic [LEN_W-1:0]   len_q;
	logic [LW-1:0]      len_ext;
	logic [LW-1:0]      eff_len;
	logic [MAX_LEN-1:0] mask;
	logic [MAX_LEN-1:0] win_q;
	logic [MAX_LEN-1:0] win_next;
	logic [MAX_LEN-1:0] pat_next;
	logic [POS_W-1:0]   cnt_q;
	logic [POS_W-1:0]   cnt_next;
	logic               dup_q;
	logic               rst_q;
	logic [AW-1:0]      clr_q;
	logic [7:0]         rd_data_s1;
	logic [MAX_LEN-1:0] res_pat_q;
	logic [POS_W-1:0]   res_pos_q;
	logic [1:0]         res_status_q;
	logic               out_valid_q;
	out_word_t          out_data_q;
	logic               hit;
	logic [7:0]         bit_sel;

	assign len_ext = LW'(len_q);
	always_comb begin
		eff_len = len_ext;
		if (len_ext < LW'(MIN_LEN)) begin
			eff_len = LW'(MIN_LEN);
		end else if (len_ext > LW'(MAX_LEN)) begin
			eff_len = LW'(MAX_LEN);
		end
	end

	assign mask     = (ONE_W << eff_len) - ONE_W;
	assign win_next = {win_q[MAX_LEN-2:0], in_data.bit_in};
	assign pat_next = win_next & mask;
	assign cnt_next = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + 1'b1;
	assign bit_sel  = 8'd1 << res_pat_q[2:0];
	assign hit      = (rd_data_s1 & bit_sel) != 8'd0;

	assign sts.in_restart = in_data.func;
	assign sts.in_fill    = cnt_next < POS_W'(eff_len);
	assign sts.rst_pend   = rst_q;
	assign sts.slot_free  = !out_valid_q || !out_stall;
	assign sts.clr_done   = clr_q == {AW{1'b1}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LEN_W'(MIN_LEN);
		end else if (cfg_wr_en) begin
			len_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
			cnt_q <= '0;
			dup_q <= 1'b0;
			rst_q <= 1'b0;
		end else if (cmd.accept) begin
			rst_q <= in_data.func;
			if (in_data.func) begin
				win_q <= '0;
				cnt_q <= '0;
				dup_q <= 1'b0;
			end else begin
				win_q <= win_next;
				cnt_q <= cnt_next;
			end
		end else if (cmd.check && !dup_q && hit) begin
			dup_q <= 1'b1;
		end
	end

	// result fields of the word at work
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			res_status_q <= STAT_FILL;
			if (in_data.func) begin
				res_pat_q <= '0;
				res_pos_q <= '0;
			end else begin
				res_pat_q <= pat_next;
				res_pos_q <= cnt_q;
			end
		end else if (cmd.check) begin
			if (dup_q) begin
				res_status_q <= STAT_LATCHED;
			end else if (hit) begin
				res_status_q <= STAT_FIRST_DUP;
			end else begin
				res_status_q <= STAT_NEW;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_en) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// seen bitmap
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			rd_data_s1 <= mem[pat_next[MAX_LEN-1:3]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_en) begin
			mem[clr_q] <= 8'd0;
		end else if (cmd.check) begin
			mem[res_pat_q[MAX_LEN-1:3]] <= rd_data_s1 | bit_sel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_data_q.status   <= res_status_q;
			out_data_q.position <= res_pos_q;
			out_data_q.pattern  <= PAT_W'(res_pat_q);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

@@ rtl/core/rbwd_ctrl.sv @@
// controller state machine sequencing accept, lookup, emit and clear
module rbwd_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  rbwd_pkg::sts_t sts,
	output rbwd_pkg::cmd_t cmd
);
	import rbwd_pkg::*;

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			S_CLEAR: begin
				if (sts.clr_done) state_next = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					state_next = (sts.in_restart || sts.in_fill) ? S_EMIT : S_READ;
				end
			end
			S_READ: begin
				state_next = S_EMIT;
			end
			S_EMIT: begin
				if (sts.slot_free) state_next = sts.rst_pend ? S_CLEAR : S_IDLE;
			end
			default: begin
				state_next = S_CLEAR;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_en = 1'b1;
			end
			S_IDLE: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
			end
			S_READ: begin
				cmd.check = 1'b1;
			end
			S_EMIT: begin
				cmd.load_out = sts.slot_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

@@ rtl/core/repeated_bit_window_detector.sv @@
// repeated bit window detector top level
// a window lookup word passes through the READ and EMIT states before out_valid rises, a
// filling or restart word through EMIT only, and EMIT waits for a free output slot; the
// block takes one word at a time, as the bitmap read-modify-write goes through a single
// memory port; reset and a restart word start a clearing pass over the bitmap, no word
// accepted meanwhile; window_len resets to 4
module repeated_bit_window_detector #(
	parameter int MAX_LEN = 20
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [rbwd_pkg::LEN_W-1:0]  cfg_wr_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  rbwd_pkg::in_word_t          in_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output rbwd_pkg::out_word_t         out_data
);
	import rbwd_pkg::*;

	cmd_t cmd;
	sts_t sts;

	rbwd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	rbwd_datapath #(
		.MAX_LEN (MAX_LEN)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_data     (in_data),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.out_data    (out_data),
		.cmd         (cmd),
		.sts         (sts)
	);

endmodule

@@ rtl/core/rbwd_checker.sv @@
// port-level checker for the repeated bit window detector and its bind
module rbwd_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  rbwd_pkg::out_word_t         out_data
);
	import rbwd_pkg::*;

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled output word changed");

	// one word at a time
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("word accepted in back-to-back cycles");

	// a looked-up window needs at least MIN_LEN bits
	a_min_position: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status != STAT_FILL) |->
			out_data.position >= POS_W'(MIN_LEN - 1))
		else $error("lookup status before window filled");

endmodule

bind repeated_bit_window_detector rbwd_checker u_rbwd_checker (.*);

@@ dv/window_dup_checker.sv @@
// checker for the repeated bit window detector: predicts each result word and compares it
`timescale 1ns / 100ps
module window_dup_checker #(
	parameter int MAX_LEN = 20
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [rbwd_pkg::LEN_W-1:0]  cfg_wr_data,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  rbwd_pkg::in_word_t          in_data,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  rbwd_pkg::out_word_t         out_data,
	output int                          errors,
	output int                          pending,
	output int                          checked,
	output int                          dup_hits
);
	import rbwd_pkg::*;

	logic [LEN_W-1:0]   win_len;
	logic [MAX_LEN-1:0] shift_bits;
	logic [POS_W-1:0]   bits_taken;
	logic               dup_seen;
	bit                 seen_pat [int unsigned];
	out_word_t          expected_reports [$];

	initial begin
		errors = 0;
		pending = 0;
		checked = 0;
		dup_hits = 0;
	end

	function automatic out_word_t next_window_report(in_word_t w);
		out_word_t        r;
		int unsigned      len;
		logic [63:0]      mask;
		logic [PAT_W-1:0] pat;
		r = '0;
		if (w.func) begin
			seen_pat.delete();
			shift_bits = '0;
			bits_taken = '0;
			dup_seen = 1'b0;
			return r;
		end
		len = (win_len < MIN_LEN) ? MIN_LEN : ((win_len > MAX_LEN) ? MAX_LEN : win_len);
		shift_bits = {shift_bits[MAX_LEN-2:0], w.bit_in};
		r.position = bits_taken;
		if (bits_taken != '1)
			bits_taken++;
		mask = (64'd1 << len) - 64'd1;
		pat = PAT_W'(shift_bits & mask[MAX_LEN-1:0]);
		r.pattern = pat;
		if (bits_taken < len) begin
			r.status = STAT_FILL;
		end else begin
			if (dup_seen) begin
				r.status = STAT_LATCHED;
			end else if (seen_pat.exists(pat)) begin
				r.status = STAT_FIRST_DUP;
				dup_seen = 1'b1;
			end else begin
				r.status = STAT_NEW;
			end
			seen_pat[pat] = 1'b1;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		out_word_t want;
		if (!arst_n) begin
			win_len = LEN_W'(MIN_LEN);
			shift_bits = '0;
			bits_taken = '0;
			dup_seen = 1'b0;
			seen_pat.delete();
			expected_reports.delete();
			pending = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_reports.size() == 0) begin
					report_mismatch("unrequested result word", 64'(out_data), '0);
				end else begin
					want = expected_reports.pop_front();
					checked++;
					if (want.status == STAT_FIRST_DUP)
						dup_hits++;
					if (out_data.status !== want.status)
						report_mismatch("status", 64'(out_data.status), 64'(want.status));
					if (out_data.position !== want.position)
						report_mismatch("position", 64'(out_data.position), 64'(want.position));
					if (out_data.pattern !== want.pattern)
						report_mismatch("pattern", 64'(out_data.pattern), 64'(want.pattern));
				end
			end
			if (in_valid && !in_stall)
				expected_reports.push_back(next_window_report(in_data));
			if (cfg_wr_en)
				win_len = cfg_wr_data;
			pending = expected_reports.size();
		end
	end

endmodule

@@ dv/repeated_bit_window_detector_tb.sv @@
// testbench top for the repeated bit window detector: stimulus, idling and verdict
`timescale 1ns / 100ps
module repeated_bit_window_detector_tb;
	import rbwd_pkg::*;

	localparam int MAX_LEN      = 20;
	localparam int CLEAR_CYCLES = 1 << (MAX_LEN - 3);
	localparam int QUIET_LIMIT  = 3 * CLEAR_CYCLES + 20000;
	localparam int DRAIN_CYCLES = 8;
	localparam int RAND_PHASES  = 12;
	localparam int PHASE_WORDS  = 142;

	localparam logic [LEN_W-1:0] LEN_PLAN [RAND_PHASES] =
		'{31, 5, 0, 20, 12, 16, 21, 4, 7, 20, 9, 3};
	localparam bit RESTART_PLAN [RAND_PHASES] =
		'{1, 0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0};

	logic             clk;
	logic             arst_n;
	logic             cfg_wr_en;
	logic [LEN_W-1:0] cfg_wr_data;
	logic             in_valid;
	logic             in_stall;
	in_word_t         in_data;
	logic             out_valid;
	logic             out_stall;
	out_word_t        out_data;

	int errors;
	int pending;
	int checked;
	int dup_hits;
	int snd_idle_pct;
	int rcv_idle_pct;
	int quiet_cycles;
	int words_sent;
	int restarts_sent;
	int cur_len;
	bit stream_hist [$];

	repeated_bit_window_detector #(.MAX_LEN(MAX_LEN)) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

	window_dup_checker #(.MAX_LEN(MAX_LEN)) checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data),
		.errors     (errors),
		.pending    (pending),
		.checked    (checked),
		.dup_hits   (dup_hits)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			out_stall <= ($urandom_range(99) < rcv_idle_pct);
		end
	end

	initial quiet_cycles = 0;

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
			$display("repeated_bit_window_detector_tb: errors");
			$finish;
		end
	end

	task automatic send_word(input in_word_t w);
		while ($urandom_range(99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		words_sent++;
		if (w.func) begin
			stream_hist.delete();
			restarts_sent++;
		end else begin
			stream_hist.push_back(w.bit_in);
		end
	endtask

	// waits for every pending result before touching the length register
	task automatic write_len(input logic [LEN_W-1:0] v);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cur_len = (v < MIN_LEN) ? MIN_LEN : ((v > MAX_LEN) ? MAX_LEN : v);
	endtask

	initial begin
		int unsigned replay_at;
		bit          replay [$];
		bit          b;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		arst_n <= 1'b0;
		words_sent = 0;
		restarts_sent = 0;
		cur_len = MIN_LEN;
		snd_idle_pct = 22;
		rcv_idle_pct = 62;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// length below the minimum acts as four
		write_len(0);
		// fill, new pattern, first duplicate, then latched
		for (int i = 0; i < 9; i++)
			send_word('{func: 1'b0, bit_in: 1'(i < 5)});
		send_word('{func: 1'b1, bit_in: 1'b1});
		// map cleared, so the all-zero window repeats once more
		repeat (5) send_word('{func: 1'b0, bit_in: 1'b0});

		for (int p = 0; p < RAND_PHASES; p++) begin
			if (p == 4) begin
				snd_idle_pct = 62;
				rcv_idle_pct = 22;
			end
			if (p == 8) begin
				snd_idle_pct = 0;
				rcv_idle_pct = 0;
			end
			write_len(LEN_PLAN[p]);
			if (RESTART_PLAN[p])
				send_word('{func: 1'b1, bit_in: 1'(p != 0)});
			replay_at = $urandom_range(PHASE_WORDS - 20, 30);
			for (int i = 0; i < PHASE_WORDS; i++) begin
				// resend the current window so that it is seen twice
				if (i == replay_at)
					for (int k = stream_hist.size() - cur_len; k < stream_hist.size(); k++)
						replay.push_back(stream_hist[k]);
				if (replay.size() != 0)
					b = replay.pop_front();
				else
					b = 1'($urandom_range(1));
				send_word('{func: 1'b0, bit_in: b});
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("sent %0d words with %0d restarts, window lengths 0 to 31, three idle mixes",
			words_sent, restarts_sent);
		$display("checked %0d result words, %0d first duplicates among them", checked, dup_hits);
		if (errors == 0)
			$display("repeated_bit_window_detector_tb: clean");
		else
			$display("repeated_bit_window_detector_tb: errors");
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/rbwd_pkg.sv
rtl/core/rbwd_datapath.sv
rtl/core/rbwd_ctrl.sv
rtl/core/repeated_bit_window_detector.sv
rtl/core/rbwd_checker.sv
dv/window_dup_checker.sv
dv/repeated_bit_window_detector_tb.sv
